/* sv/salru_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the set-associative lru tag lookup
// no dependencies

package salru_pkg;

  localparam int ADDRESS_W = 32;
  localparam int CNT_W     = 48;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SPLIT,
    ST_LOOK,
    ST_WRITE
  } state_t;

endpackage

/* sv/salru_cdiv.sv */
`timescale 1ns / 1ps
// division of an unsigned value by a fixed divisor, quotient and remainder
// shift and mask for a power of two, otherwise a reciprocal multiply then a remainder step

module salru_cdiv #(
  parameter int W       = 32,
  parameter int DIVISOR = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [W-1:0]                           dividend,
  output logic                                   done,
  output logic [W-1:0]                           quo,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem
);

  localparam int  RW     = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam bit  IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

  generate
    if (IS_POW2) begin : g_shift
      localparam int LOG = $clog2(DIVISOR);

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          quo <= dividend >> LOG;
          rem <= RW'(dividend) & RW'(DIVISOR - 1);
        end
      end
    end else begin : g_recip
      // rounded-up reciprocal, exact for every W-bit dividend
      localparam int              SH   = W + RW;
      localparam longint unsigned MULT =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

      logic [W:0]     mult_k;
      logic [2*W:0]   prod;
      logic [W-1:0]   held;
      logic           step;

      assign mult_k = (W + 1)'(MULT);
      assign prod   = (2*W + 1)'(dividend) * (2*W + 1)'(mult_k);

      always_ff @(posedge clk) begin
        if (rst) begin
          step <= 1'b0;
          done <= 1'b0;
        end else begin
          step <= start;
          done <= step;
        end
      end

      // remainder is below the divisor, so the low bits of x - q*d are enough
      always_ff @(posedge clk) begin
        if (start) begin
          held <= dividend;
          quo  <= W'(prod >> SH);
        end
        if (step) begin
          rem <= RW'(held) - quo[RW-1:0] * RW'(DIVISOR);
        end
      end
    end
  endgenerate

endmodule

/* sv/salru_lookup.sv */
`timescale 1ns / 1ps
// tag compare, way selection and recency update for one set row
// row layout per way, msb first: valid, rank, tag

module salru_lookup #(
  parameter int NUM_WAYS = 4,
  parameter int TAG_W    = 20,
  parameter int RANK_W   = 2
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [NUM_WAYS*(1+RANK_W+TAG_W)-1:0]  row,
  input  logic [TAG_W-1:0]                      tag,
  output logic                                  hit,
  output logic [NUM_WAYS*(1+RANK_W+TAG_W)-1:0]  row_next
);

  localparam int ENT_W = 1 + RANK_W + TAG_W;

  logic              in_valid [NUM_WAYS];
  logic [RANK_W-1:0] in_rank  [NUM_WAYS];
  logic [TAG_W-1:0]  in_tag   [NUM_WAYS];

  logic [NUM_WAYS-1:0] match, empty, oldest;
  logic [NUM_WAYS-1:0] hit_oh, free_oh, old_oh, sel_c;
  logic [RANK_W-1:0]   sel_rank_c;
  logic                hit_c, age_all_c;

  logic                hit_r;
  logic [NUM_WAYS-1:0] sel_r;
  logic [RANK_W-1:0]   limit_r;
  logic                age_all_r;
  logic [TAG_W-1:0]    tag_r;
  logic              q_valid [NUM_WAYS];
  logic [RANK_W-1:0] q_rank  [NUM_WAYS];
  logic [TAG_W-1:0]  q_tag   [NUM_WAYS];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      in_valid[w] = row[w*ENT_W + ENT_W - 1];
      in_rank[w]  = row[w*ENT_W + TAG_W +: RANK_W];
      in_tag[w]   = row[w*ENT_W +: TAG_W];
      match[w]    = in_valid[w] && (in_tag[w] == tag);
      empty[w]    = !in_valid[w];
      // in a full set the ranks are a permutation, so the oldest holds the top rank
      oldest[w]   = in_valid[w] && (in_rank[w] == RANK_W'(NUM_WAYS - 1));
    end
  end

  // lowest set bit of each vector
  assign hit_oh  = match  & (~match  + NUM_WAYS'(1));
  assign free_oh = empty  & (~empty  + NUM_WAYS'(1));
  assign old_oh  = oldest & (~oldest + NUM_WAYS'(1));

  assign hit_c     = |match;
  assign age_all_c = !hit_c && (|empty);
  assign sel_c     = hit_c ? hit_oh : ((|empty) ? free_oh : old_oh);

  always_comb begin
    sel_rank_c = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      sel_rank_c = sel_rank_c | (sel_c[w] ? in_rank[w] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r     <= hit_c;
      sel_r     <= sel_c;
      limit_r   <= sel_rank_c;
      age_all_r <= age_all_c;
      tag_r     <= tag;
      for (int w = 0; w < NUM_WAYS; w++) begin
        q_valid[w] <= in_valid[w];
        q_rank[w]  <= in_rank[w];
        q_tag[w]   <= in_tag[w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (sel_r[w]) begin
        row_next[w*ENT_W +: ENT_W] = {1'b1, RANK_W'(0), tag_r};
      end else if (q_valid[w] && (age_all_r || (q_rank[w] < limit_r))) begin
        row_next[w*ENT_W +: ENT_W] = {1'b1, q_rank[w] + RANK_W'(1), q_tag[w]};
      end else begin
        row_next[w*ENT_W +: ENT_W] = {q_valid[w], q_rank[w], q_tag[w]};
      end
    end
  end

  assign hit = hit_r;

endmodule

/* sv/set_assoc_lru_cache_lookup.sv */
`timescale 1ns / 1ps
// top level of the set-associative lru tag lookup: control, set memory, counters
// uses salru_pkg, salru_cdiv and salru_lookup

// One item at a time; busy is high while an item is in work. An access holds
// busy through the address split by the two dividers (the set row is read
// from the set memory at the end of the second), then tag compare and then
// write-back. A divisor that is not a power of two adds a reciprocal multiply
// step to its divider. The result shows on hit and the counts for the single
// cycle that done is high, the cycle after the last busy cycle, in which a new
// item can already be taken; there is no way to hold it off: sample it then.
// A flush gives its result in the cycle after it is taken, then busy stays high
// while the set memory is cleared one row per cycle; the same clearing pass
// runs after reset.

module set_assoc_lru_cache_lookup #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [salru_pkg::ADDRESS_W-1:0] address,
  output logic                        done,
  output logic                        hit,
  output logic [salru_pkg::CNT_W-1:0] hit_count,
  output logic [salru_pkg::CNT_W-1:0] miss_count,
  output logic [salru_pkg::CNT_W-1:0] access_count
);

  localparam int AW     = (ADDR_BITS < salru_pkg::ADDRESS_W) ? ADDR_BITS : salru_pkg::ADDRESS_W;
  localparam int LOG_BS = $clog2(BLOCK_BYTES * NUM_SETS + 1) - 1;
  localparam int TAG_W  = (AW > LOG_BS) ? AW - LOG_BS : 1;
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int OFS_W  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int ROW_W  = NUM_WAYS * (1 + RANK_W + TAG_W);
  localparam int CNT_W  = salru_pkg::CNT_W;

  salru_pkg::state_t state, state_next;

  logic accept, do_flush, do_access;
  logic mem_we, mem_re, lk_en, clearing;

  logic             div1_done, div2_done;
  logic [AW-1:0]    block_q, tag_full;
  logic [OFS_W-1:0] offset_q;
  logic [SET_W-1:0] set_q;

  logic [SET_W-1:0] set_r, clr_idx;
  logic [TAG_W-1:0] tag_r;

  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rd_data, wr_data, lk_row_next;
  logic [SET_W-1:0] wr_addr;
  logic             lk_hit;

  assign accept    = start && (state == salru_pkg::ST_IDLE);
  assign do_flush  = accept && (action == salru_pkg::ACT_FLUSH);
  assign do_access = accept && (action == salru_pkg::ACT_ACCESS);

  // block number, then set index and tag
  salru_cdiv #(.W(AW), .DIVISOR(BLOCK_BYTES)) u_div_block (
    .clk      (clk),
    .rst      (rst),
    .start    (do_access),
    .dividend (address[AW-1:0]),
    .done     (div1_done),
    .quo      (block_q),
    .rem      (offset_q)
  );

  salru_cdiv #(.W(AW), .DIVISOR(NUM_SETS)) u_div_set (
    .clk      (clk),
    .rst      (rst),
    .start    (div1_done),
    .dividend (block_q),
    .done     (div2_done),
    .quo      (tag_full),
    .rem      (set_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      salru_pkg::ST_IDLE: begin
        if (do_flush) begin
          state_next = salru_pkg::ST_CLEAR;
        end else if (do_access) begin
          state_next = salru_pkg::ST_SPLIT;
        end
      end
      salru_pkg::ST_CLEAR: begin
        if (clr_idx == SET_W'(NUM_SETS - 1)) begin
          state_next = salru_pkg::ST_IDLE;
        end
      end
      salru_pkg::ST_SPLIT: begin
        if (div2_done) begin
          state_next = salru_pkg::ST_LOOK;
        end
      end
      salru_pkg::ST_LOOK:  state_next = salru_pkg::ST_WRITE;
      salru_pkg::ST_WRITE: state_next = salru_pkg::ST_IDLE;
      default:             state_next = salru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    clearing = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    lk_en    = 1'b0;
    unique case (state)
      salru_pkg::ST_IDLE:  busy = 1'b0;
      salru_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
      end
      salru_pkg::ST_SPLIT: mem_re = div2_done;
      salru_pkg::ST_LOOK:  lk_en  = 1'b1;
      salru_pkg::ST_WRITE: mem_we = 1'b1;
      default:             busy   = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salru_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + SET_W'(1);
    end else begin
      clr_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (div2_done) begin
      set_r <= set_q;
      tag_r <= tag_full[TAG_W-1:0];
    end
  end

  // set memory, one row of all ways per set
  assign wr_addr = clearing ? clr_idx : set_r;
  assign wr_data = clearing ? '0 : lk_row_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[set_q];
    end
  end

  salru_lookup #(.NUM_WAYS(NUM_WAYS), .TAG_W(TAG_W), .RANK_W(RANK_W)) u_lookup (
    .clk      (clk),
    .en       (lk_en),
    .row      (rd_data),
    .tag      (tag_r),
    .hit      (lk_hit),
    .row_next (lk_row_next)
  );

  // saturating counters, shown directly on the result ports
  always_ff @(posedge clk) begin
    if (rst || do_flush) begin
      hit_count    <= '0;
      miss_count   <= '0;
      access_count <= '0;
    end else if (state == salru_pkg::ST_WRITE) begin
      if (access_count != {CNT_W{1'b1}}) begin
        access_count <= access_count + CNT_W'(1);
      end
      if (lk_hit) begin
        if (hit_count != {CNT_W{1'b1}}) begin
          hit_count <= hit_count + CNT_W'(1);
        end
      end else if (miss_count != {CNT_W{1'b1}}) begin
        miss_count <= miss_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= do_flush || (state == salru_pkg::ST_WRITE);
      hit  <= (state == salru_pkg::ST_WRITE) && lk_hit;
    end
  end

endmodule

/* dv/tb_set_assoc_lru_cache_lookup.sv */
`timescale 1ns / 1ps
// testbench for set_assoc_lru_cache_lookup: directed table, then random accesses and flushes
// results checked against an lru tag predictor kept here; uses salru_pkg

module tb_set_assoc_lru_cache_lookup;

  localparam int SETS = 64;
  localparam int WAYS = 4;
  localparam int OFF_W = 6;
  localparam int SET_W = 6;
  localparam int TAG_W = salru_pkg::ADDRESS_W - OFF_W - SET_W;
  localparam logic [salru_pkg::CNT_W-1:0] CNT_TOP = '1;
  localparam int RANDOM_ITEMS = 1300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int NUM_ROWS = 24;
  localparam int HOT_SETS = 3;
  localparam int HOT_TAGS = 6;

  typedef struct packed {
    logic                        hit;
    logic [salru_pkg::CNT_W-1:0] hits;
    logic [salru_pkg::CNT_W-1:0] misses;
    logic [salru_pkg::CNT_W-1:0] accesses;
  } lookup_res_t;

  typedef struct {
    logic                            act;
    logic [salru_pkg::ADDRESS_W-1:0] addr;
    logic                            typed;
    logic                            hit;
    logic [salru_pkg::CNT_W-1:0]     hits;
    logic [salru_pkg::CNT_W-1:0]     misses;
    logic [salru_pkg::CNT_W-1:0]     accesses;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic action;
  logic [salru_pkg::ADDRESS_W-1:0] address;
  logic done;
  logic hit;
  logic [salru_pkg::CNT_W-1:0] hit_count;
  logic [salru_pkg::CNT_W-1:0] miss_count;
  logic [salru_pkg::CNT_W-1:0] access_count;

  set_assoc_lru_cache_lookup uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .address      (address),
    .done         (done),
    .hit          (hit),
    .hit_count    (hit_count),
    .miss_count   (miss_count),
    .access_count (access_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [TAG_W-1:0] tag_mem [SETS][WAYS];
  logic             way_valid [SETS][WAYS];
  int unsigned      way_rank [SETS][WAYS];
  logic [salru_pkg::CNT_W-1:0] hits_seen;
  logic [salru_pkg::CNT_W-1:0] misses_seen;
  logic [salru_pkg::CNT_W-1:0] accesses_seen;

  lookup_res_t expected_q [$];
  int err_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  // typed expectation for the item now on the inputs, if its row has one
  logic        row_typed;
  lookup_res_t row_want;

  logic [SET_W-1:0] hot_sets [HOT_SETS];
  logic [TAG_W-1:0] hot_tags [HOT_TAGS];

  stim_row_t dir_rows [NUM_ROWS] = '{
    '{salru_pkg::ACT_FLUSH,  32'h0000_0000, 1'b1, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_0000, 1'b1, 1'b0, 48'd0, 48'd1, 48'd1},
    '{salru_pkg::ACT_ACCESS, 32'h0000_0000, 1'b1, 1'b1, 48'd1, 48'd1, 48'd2},
    '{salru_pkg::ACT_ACCESS, 32'hFFFF_FFFF, 1'b1, 1'b0, 48'd1, 48'd2, 48'd3},
    '{salru_pkg::ACT_ACCESS, 32'h0000_003F, 1'b1, 1'b1, 48'd2, 48'd2, 48'd4},
    '{salru_pkg::ACT_ACCESS, 32'hFFFF_FFC0, 1'b1, 1'b1, 48'd3, 48'd2, 48'd5},
    '{salru_pkg::ACT_FLUSH,  32'hFFFF_FFFF, 1'b1, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_0000, 1'b1, 1'b0, 48'd0, 48'd1, 48'd1},
    // fill set 0, then evict the oldest line four times
    '{salru_pkg::ACT_ACCESS, 32'h0000_1000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_2000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_3000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_4000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_0000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_2000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_1000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_3000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_0FC0, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h0000_0FFF, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'hFFFF_F000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h8000_0000, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h7FFF_FFFF, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'h5555_5555, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_ACCESS, 32'hAAAA_AAAA, 1'b0, 1'b0, 48'd0, 48'd0, 48'd0},
    '{salru_pkg::ACT_FLUSH,  32'h1234_5678, 1'b1, 1'b0, 48'd0, 48'd0, 48'd0}
  };

  function automatic logic [salru_pkg::CNT_W-1:0] sat_inc(logic [salru_pkg::CNT_W-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic void cache_clear();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[s][w] = '0;
        way_valid[s][w] = 1'b0;
        way_rank[s][w] = 0;
      end
    end
    hits_seen = '0;
    misses_seen = '0;
    accesses_seen = '0;
  endfunction

  // valid lines of the set younger than pivot grow one step older
  function automatic void age_set(int set_idx, int unsigned pivot);
    for (int w = 0; w < WAYS; w++) begin
      if (way_valid[set_idx][w] && way_rank[set_idx][w] < pivot) way_rank[set_idx][w]++;
    end
  endfunction

  function automatic lookup_res_t lru_lookup(logic act, logic [salru_pkg::ADDRESS_W-1:0] addr);
    int set_idx;
    int found;
    int free_w;
    int victim;
    logic [TAG_W-1:0] tag;
    lookup_res_t r;
    r = '0;
    if (act == salru_pkg::ACT_FLUSH) begin
      cache_clear();
    end else begin
      set_idx = int'(addr[OFF_W +: SET_W]);
      tag = addr[OFF_W + SET_W +: TAG_W];
      found = -1;
      free_w = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (way_valid[set_idx][w]) begin
          if (found < 0 && tag_mem[set_idx][w] == tag) found = w;
        end else if (free_w < 0) begin
          free_w = w;
        end
      end
      if (found >= 0) begin
        age_set(set_idx, way_rank[set_idx][found]);
        way_rank[set_idx][found] = 0;
        r.hit = 1'b1;
        hits_seen = sat_inc(hits_seen);
      end else begin
        if (free_w >= 0) begin
          victim = free_w;
          age_set(set_idx, 32'hFFFF_FFFF);
        end else begin
          // oldest way wins, lowest way number on a tie
          victim = 0;
          for (int w = 1; w < WAYS; w++) begin
            if (way_rank[set_idx][w] > way_rank[set_idx][victim]) victim = w;
          end
          age_set(set_idx, way_rank[set_idx][victim]);
        end
        tag_mem[set_idx][victim] = tag;
        way_valid[set_idx][victim] = 1'b1;
        way_rank[set_idx][victim] = 0;
        misses_seen = sat_inc(misses_seen);
      end
      accesses_seen = sat_inc(accesses_seen);
    end
    r.hits = hits_seen;
    r.misses = misses_seen;
    r.accesses = accesses_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [salru_pkg::CNT_W-1:0] got,
                                 logic [salru_pkg::CNT_W-1:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    err_count++;
  endtask

  // scoreboard: predict on every accepted item, check on every done strobe
  always @(posedge clk) begin : scoreboard
    lookup_res_t want;
    if (!rst) begin
      if (start && !busy) begin
        want = lru_lookup(action, address);
        if (row_typed) want = row_want;
        expected_q = {expected_q, want};
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item pending", {47'd0, hit}, '0);
        end else begin
          want = expected_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", {47'd0, hit}, {47'd0, want.hit});
          if (hit_count !== want.hits) report_mismatch("hit_count", hit_count, want.hits);
          if (miss_count !== want.misses) report_mismatch("miss_count", miss_count, want.misses);
          if (access_count !== want.accesses)
            report_mismatch("access_count", access_count, want.accesses);
        end
      end
    end
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_set_assoc_lru_cache_lookup: errors");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input logic act, input logic [salru_pkg::ADDRESS_W-1:0] addr,
                           input logic typed, input lookup_res_t want);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    action = act;
    address = addr;
    row_typed = typed;
    row_want = want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic void refresh_hot_lines();
    for (int i = 0; i < HOT_SETS; i++) hot_sets[i] = SET_W'($urandom);
    for (int i = 0; i < HOT_TAGS; i++) hot_tags[i] = TAG_W'($urandom);
  endfunction

  initial begin
    lookup_res_t want;
    logic [salru_pkg::ADDRESS_W-1:0] addr;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    action = salru_pkg::ACT_ACCESS;
    address = '0;
    row_typed = 1'b0;
    row_want = '0;
    cache_clear();
    refresh_hot_lines();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      want.hit = dir_rows[i].hit;
      want.hits = dir_rows[i].hits;
      want.misses = dir_rows[i].misses;
      want.accesses = dir_rows[i].accesses;
      send_item(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].typed, want);
    end

    // mostly accesses to a few hot sets with more tags than ways, so lines hit and get evicted
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_item(salru_pkg::ACT_FLUSH, $urandom, 1'b0, '0);
        refresh_hot_lines();
      end else if (pick < 20) begin
        send_item(salru_pkg::ACT_ACCESS, $urandom, 1'b0, '0);
      end else begin
        addr = {hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                hot_sets[$urandom_range(0, HOT_SETS - 1)], OFF_W'($urandom)};
        send_item(salru_pkg::ACT_ACCESS, addr, 1'b0, '0);
      end
      if (n % 200 == 199) refresh_hot_lines();
    end
    start = 1'b0;
    row_typed = 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_set_assoc_lru_cache_lookup: clean");
    end else begin
      $display("tb_set_assoc_lru_cache_lookup: errors");
    end
    $finish;
  end

endmodule
